@@ rtl/ptr_pkg.sv @@
// Package for the paging unit: sizes, register indexes, policy codes,
// control/status structs and the page table entry type. No dependencies.
`default_nettype none
package ptr_pkg;

	localparam int PAGE_COUNT  = 1024;
	localparam int FRAME_COUNT = 64;
	localparam int PAGE_W      = $clog2(PAGE_COUNT);
	localparam int FRAME_W     = $clog2(FRAME_COUNT);
	localparam int ALLOC_W     = FRAME_W + 1;
	localparam int OFFSET_W    = 22;
	localparam int CNT_W       = 32;
	localparam int LFSR_W      = 16;
	localparam int ADDR_W      = 32;

	localparam logic [4:0]        SHIFT_MIN = 5'd10;
	localparam logic [4:0]        SHIFT_MAX = 5'd22;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	// policy codes
	localparam logic [1:0] POL_LRU  = 2'd0;
	localparam logic [1:0] POL_FIFO = 2'd1;

	// register indexes
	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_SHIFT  = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	typedef struct packed {
		logic [1:0] policy;
		logic [4:0] shift;
		logic [6:0] limit;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [FRAME_W-1:0] frame;
	} pte_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic hit_upd;
		logic move_hit;
		logic alloc;
		logic rnd_start;
		logic move_evict;
		logic move;
		logic tail;
		logic div;
		logic vpt;
		logic vchk;
		logic inst;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic oor;
		logic hit;
		logic lru;
		logic rnd;
		logic can_alloc;
		logic move_done;
		logic div_done;
		logic fault;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/ptr_dp.sv @@
// Datapath of the paging unit: page table, frame owner and order memories,
// counters, LFSR and the serial modulo unit. Depends on ptr_pkg.
`default_nettype none
module ptr_dp (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ptr_pkg::cfg_t           cfg,
	input  ptr_pkg::cmd_t           cmd,
	output ptr_pkg::sts_t           sts,
	input  wire                     operation,
	input  wire [31:0]              address,
	output logic [5:0]              frame_index,
	output logic [21:0]             page_offset,
	output logic                    page_fault,
	output logic                    evicted,
	output logic [9:0]              evicted_page,
	output logic                    writeback,
	output logic                    out_of_range,
	output logic [31:0]             disk_reads,
	output logic [31:0]             disk_writes
);
	import ptr_pkg::*;

	logic [4:0]          sh;
	logic [ALLOC_W-1:0]  lim;
	logic [ADDR_W-1:0]   shifted;
	logic [ADDR_W-1:0]   msk;
	logic [OFFSET_W-1:0] pg_full;
	logic [OFFSET_W-1:0] off;

	// memories
	pte_t               pt_mem [PAGE_COUNT];
	pte_t               pt_rd_q;
	logic [PAGE_W-1:0]  pt_ra;
	logic               pt_we;
	logic [PAGE_W-1:0]  pt_wa;
	pte_t               pt_wd;
	logic [PAGE_W-1:0]  own_mem [FRAME_COUNT];
	logic [PAGE_W-1:0]  own_rd_q;
	logic [FRAME_W-1:0] ord_mem [FRAME_COUNT];
	logic [FRAME_W-1:0] ord_rd_q;
	logic               ord_we;
	logic [FRAME_W-1:0] ord_wa;
	logic [FRAME_W-1:0] ord_wd;

	// control state
	logic [PAGE_W-1:0]  clr_idx_q;
	logic [ALLOC_W-1:0] alloc_q;
	logic [ALLOC_W-1:0] alloc_m1;
	logic [CNT_W-1:0]   rcnt_q;
	logic [CNT_W-1:0]   wcnt_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic [LFSR_W-1:0]  lfsr_nxt;
	logic               rv_s1;
	logic [ALLOC_W-1:0] ri_q;
	logic [ALLOC_W-1:0] di_s1;
	logic               found_q;
	logic               evmode_q;
	logic [3:0]         dcnt_q;

	// payload
	logic                op_q;
	logic [PAGE_W-1:0]   page_q;
	logic                oor_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                fault_q;
	logic                evict_q;
	logic [PAGE_W-1:0]   vpage_q;
	logic                wb_q;
	logic [FRAME_W-1:0]  target_q;
	logic [LFSR_W-1:0]   dvd_q;
	logic [ALLOC_W-1:0]  rem_sh;
	logic [FRAME_W-1:0]  rem_n;

	// clamp configuration
	always_comb begin
		if (cfg.shift < SHIFT_MIN) begin
			sh = SHIFT_MIN;
		end else if (cfg.shift > SHIFT_MAX) begin
			sh = SHIFT_MAX;
		end else begin
			sh = cfg.shift;
		end
		if (cfg.limit == '0) begin
			lim = ALLOC_W'(1);
		end else if (cfg.limit > ALLOC_W'(FRAME_COUNT)) begin
			lim = ALLOC_W'(FRAME_COUNT);
		end else begin
			lim = cfg.limit;
		end
	end

	assign shifted  = address >> sh;
	assign pg_full  = shifted[OFFSET_W-1:0];
	assign msk      = (ADDR_W'(1) << sh) - ADDR_W'(1);
	assign off      = address[OFFSET_W-1:0] & msk[OFFSET_W-1:0];
	assign alloc_m1 = alloc_q - ALLOC_W'(1);
	assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};

	// restoring modulo, one dividend bit a cycle; frame_q holds the remainder
	always_comb begin
		rem_sh = {frame_q, dvd_q[LFSR_W-1]};
		if (rem_sh >= lim) begin
			rem_n = FRAME_W'(rem_sh - lim);
		end else begin
			rem_n = rem_sh[FRAME_W-1:0];
		end
	end

	// page table port
	always_comb begin
		pt_ra = cmd.vpt ? own_rd_q : pg_full[PAGE_W-1:0];
		pt_we = 1'b0;
		pt_wa = page_q;
		pt_wd = '0;
		if (cmd.clr) begin
			pt_we = 1'b1;
			pt_wa = clr_idx_q;
		end else if (cmd.hit_upd) begin
			pt_we = 1'b1;
			pt_wd = '{valid: 1'b1, dirty: pt_rd_q.dirty | op_q, frame: pt_rd_q.frame};
		end else if (cmd.vchk) begin
			pt_we = 1'b1;
			pt_wa = vpage_q;
		end else if (cmd.inst) begin
			pt_we = 1'b1;
			pt_wd = '{valid: 1'b1, dirty: op_q, frame: frame_q};
		end
	end

	// order list port
	always_comb begin
		ord_we = 1'b0;
		ord_wa = alloc_q[FRAME_W-1:0];
		ord_wd = alloc_q[FRAME_W-1:0];
		if (cmd.alloc) begin
			ord_we = 1'b1;
		end else if (cmd.move && rv_s1 && found_q) begin
			ord_we = 1'b1;
			ord_wa = FRAME_W'(di_s1 - ALLOC_W'(1));
			ord_wd = ord_rd_q;
		end else if (cmd.tail) begin
			ord_we = 1'b1;
			ord_wa = alloc_m1[FRAME_W-1:0];
			ord_wd = target_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_wa] <= pt_wd;
		end
		pt_rd_q <= pt_mem[pt_ra];
		if (cmd.inst) begin
			own_mem[frame_q] <= page_q;
		end
		own_rd_q <= own_mem[frame_q];
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		ord_rd_q <= ord_mem[ri_q[FRAME_W-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			alloc_q   <= '0;
			rcnt_q    <= '0;
			wcnt_q    <= '0;
			lfsr_q    <= LFSR_SEED;
			rv_s1     <= 1'b0;
			ri_q      <= '0;
			di_s1     <= '0;
			found_q   <= 1'b0;
			evmode_q  <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + PAGE_W'(1);
			end
			if (cmd.alloc) begin
				alloc_q <= alloc_q + ALLOC_W'(1);
			end
			if (cmd.inst && rcnt_q != '1) begin
				rcnt_q <= rcnt_q + CNT_W'(1);
			end
			if (cmd.vchk && pt_rd_q.dirty && wcnt_q != '1) begin
				wcnt_q <= wcnt_q + CNT_W'(1);
			end
			if (cmd.rnd_start) begin
				lfsr_q <= lfsr_nxt;
				dcnt_q <= '0;
			end else if (cmd.div) begin
				dcnt_q <= dcnt_q + 4'd1;
			end
			if (cmd.move_hit || cmd.move_evict) begin
				rv_s1    <= 1'b0;
				ri_q     <= '0;
				found_q  <= 1'b0;
				evmode_q <= cmd.move_evict;
			end else if (cmd.move) begin
				rv_s1 <= (ri_q < alloc_q);
				di_s1 <= ri_q;
				if (ri_q < alloc_q) begin
					ri_q <= ri_q + ALLOC_W'(1);
				end
				if (rv_s1) begin
					if (evmode_q && di_s1 == '0) begin
						found_q <= 1'b1;
					end else if (!found_q && ord_rd_q == target_q) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= operation;
			page_q   <= pg_full[PAGE_W-1:0];
			oor_q    <= |pg_full[OFFSET_W-1:PAGE_W];
			offset_q <= off;
			frame_q  <= '0;
			fault_q  <= 1'b0;
			evict_q  <= 1'b0;
			vpage_q  <= '0;
			wb_q     <= 1'b0;
		end
		if (cmd.hit_upd) begin
			frame_q <= pt_rd_q.frame;
		end
		if (cmd.move_hit) begin
			target_q <= pt_rd_q.frame;
		end
		if (cmd.alloc) begin
			fault_q <= 1'b1;
			frame_q <= alloc_q[FRAME_W-1:0];
		end
		if (cmd.rnd_start || cmd.move_evict) begin
			fault_q <= 1'b1;
			evict_q <= 1'b1;
		end
		if (cmd.rnd_start) begin
			dvd_q   <= lfsr_nxt;
			frame_q <= '0;
		end
		if (cmd.div) begin
			dvd_q   <= dvd_q << 1;
			frame_q <= rem_n;
		end
		if (cmd.move && rv_s1 && evmode_q && di_s1 == '0) begin
			target_q <= ord_rd_q;
		end
		if (cmd.tail) begin
			frame_q <= target_q;
		end
		if (cmd.vpt) begin
			vpage_q <= own_rd_q;
		end
		if (cmd.vchk) begin
			wb_q <= pt_rd_q.dirty;
		end
	end

	always_comb begin
		sts.clr_done  = (clr_idx_q == '1);
		sts.oor       = oor_q;
		sts.hit       = pt_rd_q.valid;
		sts.lru       = (cfg.policy == POL_LRU);
		sts.rnd       = (cfg.policy != POL_LRU) && (cfg.policy != POL_FIFO);
		sts.can_alloc = (alloc_q < lim);
		sts.move_done = rv_s1 && (di_s1 == alloc_m1);
		sts.div_done  = (dcnt_q == 4'hF);
		sts.fault     = fault_q;
	end

	assign frame_index  = frame_q;
	assign page_offset  = offset_q;
	assign page_fault   = fault_q;
	assign evicted      = evict_q;
	assign evicted_page = vpage_q;
	assign writeback    = wb_q;
	assign out_of_range = oor_q;
	assign disk_reads   = rcnt_q;
	assign disk_writes  = wcnt_q;

`ifndef SYNTHESIS
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= ALLOC_W'(FRAME_COUNT))
		else $error("allocated frame count past frame total");
	a_alloc_lim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> (alloc_q < lim))
		else $error("frame allocated beyond limit");
	a_tail_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tail |-> found_q)
		else $error("order list pass ended without finding its frame");
`endif
endmodule
`default_nettype wire

@@ rtl/ptr_ctrl.sv @@
// Sequencer of the paging unit: clearing pass, lookup, order list pass,
// random victim and install steps. Depends on ptr_pkg.
`default_nettype none
module ptr_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  ptr_pkg::sts_t sts,
	output ptr_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import ptr_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOOK, S_MOVE, S_TAIL, S_DIV,
		S_VOWN, S_VPT, S_VCHK, S_INST, S_DONE
	} state_t;

	state_t state_q, nxt;
	logic   busy_q, done_q;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				priority if (sts.oor) begin
					nxt = S_DONE;
				end else if (sts.hit) begin
					cmd.hit_upd  = 1'b1;
					cmd.move_hit = sts.lru;
					nxt = sts.lru ? S_MOVE : S_DONE;
				end else if (sts.can_alloc) begin
					cmd.alloc = 1'b1;
					nxt = S_INST;
				end else if (sts.rnd) begin
					cmd.rnd_start = 1'b1;
					nxt = S_DIV;
				end else begin
					cmd.move_evict = 1'b1;
					nxt = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				if (sts.move_done) nxt = S_TAIL;
			end
			S_TAIL: begin
				cmd.tail = 1'b1;
				nxt = sts.fault ? S_VOWN : S_DONE;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) nxt = S_VOWN;
			end
			S_VOWN: nxt = S_VPT;
			S_VPT: begin
				cmd.vpt = 1'b1;
				nxt = S_VCHK;
			end
			S_VCHK: begin
				cmd.vchk = 1'b1;
				nxt = S_INST;
			end
			S_INST: begin
				cmd.inst = 1'b1;
				nxt = S_DONE;
			end
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= nxt;
			busy_q  <= (nxt != S_IDLE);
			done_q  <= (nxt == S_DONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

@@ rtl/page_table_with_replacement_unit.sv @@
// Paging unit top: APB register file, sequencer and datapath. Uses ptr_pkg,
// ptr_ctrl and ptr_dp.
// One word at a time; the order list pass reads one entry a cycle.
// After reset a clearing pass over the 1024 page table entries holds busy;
// registers can be written meanwhile. done cannot be stalled.
`default_nettype none
module page_table_with_replacement_unit (
	input  wire         clk,
	input  wire         arst_n,
	// command channel
	input  wire         start,
	output logic        busy,
	input  wire         operation,
	input  wire  [31:0] address,
	// result word, valid for the single cycle of done
	output logic        done,
	output logic [5:0]  frame_index,
	output logic [21:0] page_offset,
	output logic        page_fault,
	output logic        evicted,
	output logic [9:0]  evicted_page,
	output logic        writeback,
	output logic        out_of_range,
	output logic [31:0] disk_reads,
	output logic [31:0] disk_writes,
	// register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ptr_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr;

	// registers at byte offsets 0, 4, 8; writes land in the access phase
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy <= POL_LRU;
			cfg_q.shift  <= 5'd12;
			cfg_q.limit  <= 7'(FRAME_COUNT);
		end else if (wr) begin
			case (paddr[3:2])
				REG_POLICY: cfg_q.policy <= pwdata[1:0];
				REG_SHIFT:  cfg_q.shift  <= pwdata[4:0];
				REG_LIMIT:  cfg_q.limit  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_POLICY: prdata = {30'd0, cfg_q.policy};
			REG_SHIFT:  prdata = {27'd0, cfg_q.shift};
			REG_LIMIT:  prdata = {25'd0, cfg_q.limit};
			default:    prdata = '0;
		endcase
	end

	ptr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ptr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.address      (address),
		.frame_index  (frame_index),
		.page_offset  (page_offset),
		.page_fault   (page_fault),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.writeback    (writeback),
		.out_of_range (out_of_range),
		.disk_reads   (disk_reads),
		.disk_writes  (disk_writes)
	);
endmodule
`default_nettype wire

@@ test/tb_page_table_with_replacement_unit.sv @@
`timescale 1ns / 1ps
// Testbench for the paging unit: directed table, per-policy and range phases, then random
// accesses, every result word checked against a behavioural translation model. Uses ptr_pkg.
`default_nettype none
module tb_page_table_with_replacement_unit;
	import ptr_pkg::*;

	localparam int CLK_HALF  = 2;
	localparam int CYC_LIMIT = 1500000;
	localparam int N_RANDOM  = 1000;
	localparam int N_ROWS    = 6;

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;
	localparam logic [1:0] POL_RANDOM = 2'd2;
	localparam logic [1:0] POL_SPARE  = 2'd3;

	typedef struct packed {
		logic [5:0]  frame;
		logic [21:0] offset;
		logic        fault;
		logic        evict;
		logic [9:0]  victim;
		logic        wb;
		logic        oor;
		logic [31:0] reads;
		logic [31:0] writes;
	} xlat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = 1'b0;
	logic [31:0] address = '0;
	logic        done;
	logic [5:0]  frame_index;
	logic [21:0] page_offset;
	logic        page_fault, evicted, writeback, out_of_range;
	logic [9:0]  evicted_page;
	logic [31:0] disk_reads, disk_writes;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	always #CLK_HALF clk = ~clk;

	page_table_with_replacement_unit u_top (.*);

	// model state
	logic [5:0]  m_pft [PAGE_COUNT];
	logic        m_valid [PAGE_COUNT];
	logic        m_dirty [PAGE_COUNT];
	logic [9:0]  m_owner [FRAME_COUNT];
	logic [5:0]  m_order [FRAME_COUNT];
	int unsigned m_alloc;
	logic [31:0] m_loads, m_wbs;
	logic [15:0] m_lfsr;
	logic [1:0]  m_pol;
	logic [4:0]  m_shift;
	logic [6:0]  m_limit;

	xlat_t expected_q[$];
	int    n_fail = 0;
	bit    have_fixed;
	xlat_t fixed;

	function automatic logic [31:0] sat_up(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// move order list entry at pos to the tail
	function automatic void to_tail(int unsigned pos);
		logic [5:0] f;
		if (pos >= m_alloc) return;
		f = m_order[pos];
		for (int unsigned i = pos; i + 1 < m_alloc; i++) m_order[i] = m_order[i + 1];
		m_order[m_alloc - 1] = f;
	endfunction

	function automatic xlat_t translate(logic op, logic [31:0] addr);
		xlat_t r;
		int unsigned sh, lim, pg;
		logic fb;
		r = '0;
		sh = 32'(m_shift);
		lim = 32'(m_limit);
		if (sh < 32'(SHIFT_MIN)) sh = 32'(SHIFT_MIN);
		if (sh > 32'(SHIFT_MAX)) sh = 32'(SHIFT_MAX);
		if (lim < 1) lim = 1;
		if (lim > FRAME_COUNT) lim = FRAME_COUNT;
		pg = addr >> sh;
		r.offset = 22'(addr & ((32'd1 << sh) - 32'd1));
		if (pg >= PAGE_COUNT) begin
			r.oor = 1'b1;
		end else if (m_valid[pg]) begin
			r.frame = m_pft[pg];
			if (m_pol == POL_LRU) begin
				for (int unsigned i = 0; i < m_alloc; i++)
					if (m_order[i] == r.frame) begin
						to_tail(i);
						break;
					end
			end
		end else begin
			r.fault = 1'b1;
			if (m_alloc < lim) begin
				r.frame = 6'(m_alloc);
				m_order[m_alloc] = 6'(m_alloc);
				m_alloc++;
			end else begin
				if (m_pol >= POL_RANDOM) begin
					fb = m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5];
					m_lfsr = {fb, m_lfsr[15:1]};
					r.frame = 6'(32'(m_lfsr) % lim);
				end else begin
					r.frame = m_order[0];
					to_tail(0);
				end
				r.victim = m_owner[r.frame];
				r.evict = 1'b1;
				if (m_dirty[r.victim]) begin
					r.wb = 1'b1;
					m_wbs = sat_up(m_wbs);
				end
				m_valid[r.victim] = 1'b0;
				m_dirty[r.victim] = 1'b0;
			end
			m_loads = sat_up(m_loads);
			m_valid[pg] = 1'b1;
			m_pft[pg] = r.frame;
			m_owner[r.frame] = 10'(pg);
		end
		if (!r.oor && op) m_dirty[pg] = 1'b1;
		r.reads = m_loads;
		r.writes = m_wbs;
		return r;
	endfunction

	initial begin
		for (int i = 0; i < PAGE_COUNT; i++) begin
			m_valid[i] = 1'b0;
			m_dirty[i] = 1'b0;
			m_pft[i] = '0;
		end
		for (int i = 0; i < FRAME_COUNT; i++) begin
			m_owner[i] = '0;
			m_order[i] = '0;
		end
		m_alloc = 0;
		m_loads = '0;
		m_wbs = '0;
		m_lfsr = LFSR_SEED;
		m_pol = POL_LRU;
		m_shift = 5'd12;
		m_limit = 7'd64;
	end

	// result checker
	always @(posedge clk) begin
		xlat_t got, want;
		if (arst_n && done) begin
			got = '{frame_index, page_offset, page_fault, evicted, evicted_page,
				writeback, out_of_range, disk_reads, disk_writes};
			if (expected_q.size() == 0) begin
				$display("%0t: result word with nothing expected, got %h", $time, got);
				n_fail++;
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				if (got.frame !== want.frame)
					$display("%0t: frame_index exp %0d got %0d", $time, want.frame, got.frame);
				if (got.offset !== want.offset)
					$display("%0t: page_offset exp %h got %h", $time, want.offset, got.offset);
				if (got.fault !== want.fault)
					$display("%0t: page_fault exp %b got %b", $time, want.fault, got.fault);
				if (got.evict !== want.evict)
					$display("%0t: evicted exp %b got %b", $time, want.evict, got.evict);
				if (got.victim !== want.victim)
					$display("%0t: evicted_page exp %0d got %0d", $time, want.victim,
						got.victim);
				if (got.wb !== want.wb)
					$display("%0t: writeback exp %b got %b", $time, want.wb, got.wb);
				if (got.oor !== want.oor)
					$display("%0t: out_of_range exp %b got %b", $time, want.oor, got.oor);
				if (got.reads !== want.reads)
					$display("%0t: disk_reads exp %0d got %0d", $time, want.reads, got.reads);
				if (got.writes !== want.writes)
					$display("%0t: disk_writes exp %0d got %0d", $time, want.writes,
						got.writes);
				if (got !== want) n_fail++;
			end
		end
	end

	// watchdog
	int unsigned cyc = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// register write, only while idle
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_POLICY: m_pol = val[1:0];
			REG_SHIFT:  m_shift = val[4:0];
			default:    m_limit = val[6:0];
		endcase
	endtask

	// drop start, drain, then let any tail of work settle
	task automatic settle();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	int unsigned burst_left = 0;

	// one access word; optional fixed expectation checked first
	task automatic issue(logic op, logic [31:0] addr);
		xlat_t       e;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		operation <= op;
		address <= addr;
		do @(posedge clk); while (busy);
		e = translate(op, addr);
		if (have_fixed && e !== fixed) begin
			$display("%0t: directed row exp %h model %h", $time, fixed, e);
			n_fail++;
		end
		expected_q = {expected_q, e};
	endtask

	// directed rows
	typedef struct {
		logic        op;
		logic [31:0] addr;
		bit          fixed_ok;
		xlat_t       res;
	} row_t;

	row_t rows[N_ROWS];
	logic [31:0] a;
	int unsigned n;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// after reset: first fault takes frame 0
		rows[0] = '{OP_READ, 32'h0000_0000, 1, '{6'd0, 22'd0, 1'b1, 1'b0, 10'd0,
			1'b0, 1'b0, 32'd1, 32'd0}};
		rows[1] = '{OP_WRITE, 32'h0000_0FFF, 1, '{6'd0, 22'hFFF, 1'b0, 1'b0, 10'd0,
			1'b0, 1'b0, 32'd1, 32'd0}};
		// top of address space: out of range at shift 12
		rows[2] = '{OP_WRITE, 32'hFFFF_FFFF, 1, '{6'd0, 22'hFFF, 1'b0, 1'b0, 10'd0,
			1'b0, 1'b1, 32'd1, 32'd0}};
		rows[3] = '{OP_READ, 32'h003F_F000, 0, '0};
		rows[4] = '{OP_WRITE, 32'h0040_0000, 0, '0};
		rows[5] = '{OP_READ, 32'h0000_1234, 0, '0};
		foreach (rows[i]) begin
			have_fixed = rows[i].fixed_ok;
			fixed = rows[i].res;
			issue(rows[i].op, rows[i].addr);
		end
		have_fixed = 0;
		settle();
		// small frame limit under each policy, including spare code, both shift extremes
		for (int p = 0; p < 4; p++) begin
			reg_write(REG_POLICY, p);
			reg_write(REG_LIMIT, (p == POL_SPARE) ? 0 : 3);
			reg_write(REG_SHIFT, (p[0]) ? 22 : 10);
			for (int k = 0; k < 6; k++)
				issue(k[0], $urandom_range(0, 7) << ((p[0]) ? 22 : 10));
			settle();
		end
		// out of range shift codes and limits
		reg_write(REG_SHIFT, 31);
		reg_write(REG_LIMIT, 127);
		issue(OP_WRITE, 32'hFFFF_FFFF);
		settle();
		reg_write(REG_SHIFT, 0);
		issue(OP_READ, 32'hFFFF_FFFF);
		settle();
		// random phases: rotate settings; mostly a small working set of pages
		n = 0;
		while (n < N_RANDOM) begin
			int unsigned sh, span;
			sh = $urandom_range(10, 22);
			reg_write(REG_POLICY, $urandom_range(0, 3));
			reg_write(REG_SHIFT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : sh);
			reg_write(REG_LIMIT, ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 12));
			span = $urandom_range(4, 80);
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(0, 19) == 0)
					a = $urandom();
				else
					a = ($urandom_range(0, span - 1) << m_shift) ^
						($urandom() & ((32'd1 << m_shift) - 32'd1));
				if (m_shift < 10 || m_shift > 22) a = $urandom();
				issue(1'($urandom_range(0, 1)), a);
				n++;
			end
			settle();
		end
		settle();
		if (n_fail == 0 && expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
rtl/ptr_pkg.sv
rtl/ptr_dp.sv
rtl/ptr_ctrl.sv
rtl/page_table_with_replacement_unit.sv
test/tb_page_table_with_replacement_unit.sv
